// ----- hw/rtl/lrg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lrg_pkg;

    // 64-bit LCG step: state * LCG_MUL + LCG_INC, modulo 2^64
    localparam logic [63:0] LCG_MUL = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] LCG_INC = 64'd1;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    localparam int unsigned ADDR_W = 5;

    localparam logic [1:0] REG_SEED = 2'd0;
    localparam logic [1:0] REG_LOW  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_MOD,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/lrg_lcg.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Advances the generator state with one 32x32 multiplier over four phases.
// Only the low 64 bits are kept, so the high-by-high partial product is not needed.
module lrg_lcg
    import lrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_state,
    output logic             o_done,
    output logic [63:0]      o_next
);

    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [1:0]  r_phase;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_addend;

    // phase 0: aL*mL, phase 1: aL*mH, phase 2: aH*mL
    assign w_ma   = (r_phase == 2'd2) ? r_a[63:32] : r_a[31:0];
    assign w_mb   = (r_phase == 2'd1) ? LCG_MUL[63:32] : LCG_MUL[31:0];
    assign w_prod = w_ma * w_mb;

    // product registered in phase k is folded in at phase k+1
    always_comb begin
        case (r_phase)
            2'd0:    w_addend = '0;
            2'd1:    w_addend = r_prod;
            default: w_addend = {r_prod[31:0], 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= '0;
        end else begin
            r_done <= r_busy && (r_phase == 2'd3);
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_state;
            r_acc <= LCG_INC;
        end else if (r_busy) begin
            r_prod <= w_prod;
            r_acc  <= r_acc + w_addend;
        end
    end

    assign o_done = r_done;
    assign o_next = r_acc;

endmodule

`default_nettype wire

// ----- hw/rtl/lrg_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
// Divisor is 1 .. 2^32, so the remainder always fits in 32 bits.
module lrg_mod (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [32:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_rem
);

    logic [32:0] r_rem;
    logic [63:0] r_dvd;
    logic [32:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [33:0] w_trial;
    logic [33:0] w_diff;
    logic        w_ge;
    logic [32:0] n_rem;

    assign w_trial = {r_rem, r_dvd[63]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign n_rem   = w_ge ? w_diff[32:0] : w_trial[32:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[62:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[31:0];

endmodule

`default_nettype wire

// ----- hw/rtl/lcg_range_generator_with_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_last
// result    out        o_valid / i_ready    o_value, o_running_sum, o_item_count,
//                                           o_run_end, o_bad_range
// config    in         APB psel / penable   paddr, pwdata, prdata (64-bit regs at 8*i)
//
// One transaction at a time: the 4-phase state multiply runs first, then the
// 64-step remainder loop produces the result.
// With range_low > range_high the remainder is skipped.
// o_ready is high in idle; a pending result may wait at the output register.
// Synchronous active-low reset loads seed 0, low 0, high 0xFFFFFFFF.
module lcg_range_generator_with_sum
    import lrg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_last,

    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [31:0]            o_value,
    output logic [63:0]            o_running_sum,
    output logic [31:0]            o_item_count,
    output logic                   o_run_end,
    output logic                   o_bad_range,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    t_state r_state;
    t_state n_state;

    logic [63:0] r_seed;
    logic [31:0] r_lo;
    logic [31:0] r_hi;
    logic [63:0] r_gen;
    logic [63:0] r_sum;
    logic [31:0] r_cnt;

    logic        r_last;
    logic        r_bad;
    logic [32:0] r_span;
    logic [31:0] r_val;

    logic        r_o_valid;
    logic [31:0] r_o_value;
    logic [63:0] r_o_sum;
    logic [31:0] r_o_cnt;
    logic        r_o_end;
    logic        r_o_bad;

    logic        w_accept;
    logic        w_cfg_wr;
    logic [1:0]  w_idx;
    logic        w_lcg_start;
    logic        w_lcg_done;
    logic [63:0] w_lcg_next;
    logic        w_mod_start;
    logic        w_mod_done;
    logic [31:0] w_rem;
    logic        w_out_load;
    logic        w_out_free;
    logic [63:0] n_sum;
    logic [31:0] n_cnt;

    assign w_idx    = paddr[ADDR_W-1:3];
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        case (w_idx)
            REG_SEED: prdata = r_seed;
            REG_LOW:  prdata = {32'd0, r_lo};
            REG_HIGH: prdata = {32'd0, r_hi};
            default:  prdata = '0;
        endcase
    end

    assign w_out_free = !r_o_valid || i_ready;
    assign w_accept   = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_ADV;
            ST_ADV: begin
                if (w_lcg_done) n_state = r_bad ? ST_OUT : ST_MOD;
            end
            ST_MOD:  if (w_mod_done) n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready     = 1'b0;
        w_lcg_start = 1'b0;
        w_mod_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready     = 1'b1;
                w_lcg_start = i_valid;
            end
            ST_ADV:  w_mod_start = w_lcg_done && !r_bad;
            ST_MOD:  ;
            ST_OUT:  w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    lrg_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lcg_start),
        .i_state (r_gen),
        .o_done  (w_lcg_done),
        .o_next  (w_lcg_next)
    );

    lrg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_lcg_next),
        .i_divisor  (r_span),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    assign n_sum = r_sum + {32'd0, r_val};
    assign n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 32'd1;

    // run state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_lo   <= '0;
            r_hi   <= CNT_MAX;
            r_gen  <= '0;
            r_sum  <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (w_idx)
                    REG_SEED: begin
                        r_seed <= pwdata;
                        r_gen  <= pwdata;
                        r_sum  <= '0;
                        r_cnt  <= '0;
                    end
                    REG_LOW:  r_lo <= pwdata[31:0];
                    REG_HIGH: r_hi <= pwdata[31:0];
                    default:  ;
                endcase
            end
            if (r_state == ST_ADV && w_lcg_done) begin
                r_gen <= w_lcg_next;
            end
            if (w_out_load) begin
                if (r_last) begin
                    r_gen <= r_seed;
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    // per-transaction payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_last;
            r_bad  <= (r_lo > r_hi);
            r_span <= {1'b0, r_hi} - {1'b0, r_lo} + 33'd1;
        end
        if (r_state == ST_ADV && w_lcg_done) begin
            r_val <= '0;
        end
        if (w_mod_done) begin
            r_val <= w_rem + r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_value <= r_val;
            r_o_sum   <= n_sum;
            r_o_cnt   <= n_cnt;
            r_o_end   <= r_last;
            r_o_bad   <= r_bad;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_value       = r_o_value;
    assign o_running_sum = r_o_sum;
    assign o_item_count  = r_o_cnt;
    assign o_run_end     = r_o_end;
    assign o_bad_range   = r_o_bad;

    a_lcg_done_in_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lcg_done |-> r_state == ST_ADV)
        else $error("state update finished outside its phase");

    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> r_state == ST_MOD)
        else $error("remainder finished outside its phase");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_ADV)
        else $error("accepted transaction did not start the state update");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item_count != 32'd0)
        else $error("result with zero item count");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_range) |-> o_value == 32'd0)
        else $error("bad range result carries a nonzero value");

endmodule

`default_nettype wire

// ----- tb/lcg_range_generator_with_sum_tb.sv -----
`timescale 1ns / 1ps

module lcg_range_generator_with_sum_tb;
    import lrg_pkg::*;

    localparam logic [63:0] STEP_MUL     = 64'd6364136223846793005;
    localparam logic [63:0] STEP_INC     = 64'd1;
    localparam logic [31:0] COUNT_TOP    = 32'hFFFF_FFFF;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam int          TARGET_ITEMS = 850;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_LIMIT  = 3000;
    localparam int          SETTLE       = 8;
    localparam int          TAIL_CYCLES  = 100;

    typedef struct {
        logic [31:0] value;
        logic [63:0] running_sum;
        logic [31:0] item_count;
        logic        run_end;
        logic        bad_range;
    } t_draw;

    class draw_scoreboard;
        logic [63:0] seed;
        logic [31:0] range_lo;
        logic [31:0] range_hi;
        logic [63:0] gen_state;
        logic [63:0] sum_acc;
        logic [31:0] count;
        t_draw       draws_due[$];
        int          errors;
        int          n_checked;
        int          n_bad;
        int          n_runs;

        function new();
            seed      = 64'd0;
            range_lo  = 32'd0;
            range_hi  = 32'hFFFF_FFFF;
            errors    = 0;
            n_checked = 0;
            n_bad     = 0;
            n_runs    = 0;
            restart_run();
        endfunction

        function void restart_run();
            gen_state = seed;
            sum_acc   = 64'd0;
            count     = 32'd0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                REG_SEED: begin
                    seed = data;
                    restart_run();
                end
                REG_LOW:  range_lo = data[31:0];
                REG_HIGH: range_hi = data[31:0];
                default: ;
            endcase
        endfunction

        // Advance the generator and queue the draw this request should produce.
        function void note_request(logic last);
            t_draw       d;
            logic [32:0] span;
            logic [63:0] rem;
            gen_state   = gen_state * STEP_MUL + STEP_INC;
            d.bad_range = range_lo > range_hi;
            d.value     = 32'd0;
            if (!d.bad_range) begin
                span    = {1'b0, range_hi} - {1'b0, range_lo} + 33'd1;
                rem     = gen_state % {31'd0, span};
                d.value = rem[31:0] + range_lo;
            end
            sum_acc = sum_acc + {32'd0, d.value};
            if (count != COUNT_TOP)
                count = count + 32'd1;
            d.running_sum = sum_acc;
            d.item_count  = count;
            d.run_end     = last;
            draws_due.push_back(d);
            if (last)
                restart_run();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $time, what);
            else if (errors == 41)
                $display("[%0t] further mismatches counted but not shown", $time);
        endtask

        task check_draw(t_draw got);
            t_draw want;
            if (draws_due.size() == 0) begin
                report("result transaction with nothing outstanding");
                return;
            end
            want = draws_due.pop_front();
            n_checked++;
            if (want.bad_range)
                n_bad++;
            if (want.run_end)
                n_runs++;
            if (got.value !== want.value)
                report($sformatf("value %h, want %h", got.value, want.value));
            if (got.running_sum !== want.running_sum)
                report($sformatf("running_sum %h, want %h", got.running_sum,
                                 want.running_sum));
            if (got.item_count !== want.item_count)
                report($sformatf("item_count %h, want %h", got.item_count,
                                 want.item_count));
            if (got.run_end !== want.run_end)
                report($sformatf("run_end %b, want %b", got.run_end, want.run_end));
            if (got.bad_range !== want.bad_range)
                report($sformatf("bad_range %b, want %b", got.bad_range,
                                 want.bad_range));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_last;
    logic              o_valid;
    logic              i_ready;
    logic [31:0]       o_value;
    logic [63:0]       o_running_sum;
    logic [31:0]       o_item_count;
    logic              o_run_end;
    logic              o_bad_range;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    draw_scoreboard sb = new();
    int             gap_max = 12;
    bit             hold_receiver = 0;
    int             items_sent = 0;
    int             reg_writes = 0;
    int             quiet = 0;

    lcg_range_generator_with_sum i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value       (o_value),
        .o_running_sum (o_running_sum),
        .o_item_count  (o_item_count),
        .o_run_end     (o_run_end),
        .o_bad_range   (o_bad_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic last);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_run(int n);
        for (int k = 0; k < n; k++)
            send_item($urandom_range(0, 7) == 0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.draws_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic apb_read(logic [1:0] idx, output logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_regs();
        logic [63:0] got;
        apb_read(REG_SEED, got);
        if (got !== sb.seed)
            sb.report($sformatf("seed reads %h, want %h", got, sb.seed));
        apb_read(REG_LOW, got);
        if (got[31:0] !== sb.range_lo)
            sb.report($sformatf("range_low reads %h, want %h", got[31:0], sb.range_lo));
        apb_read(REG_HIGH, got);
        if (got[31:0] !== sb.range_hi)
            sb.report($sformatf("range_high reads %h, want %h", got[31:0], sb.range_hi));
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_side
        t_draw got;
        int    gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_receiver) begin
                gap           = HOLD_CYCLES;
                hold_receiver = 0;
            end else begin
                gap = $urandom_range(0, gap_max);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.value       = o_value;
            got.running_sum = o_running_sum;
            got.item_count  = o_item_count;
            got.run_end     = o_run_end;
            got.bad_range   = o_bad_range;
            sb.check_draw(got);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles, giving up", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] lo;
        logic [31:0] hi;
        int          phase;
        int          n;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_last  = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = 64'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values: seed 0, full range; run ends, then a new one starts.
        check_regs();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();

        // Seed write in the middle of a run restarts it; low == high == max.
        apb_write(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(REG_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        check_regs();
        send_item(1'b0);
        send_item(1'b1);
        drain();

        // Single-value range at zero, then widen it without touching the run.
        apb_write(REG_LOW, 64'd0);
        apb_write(REG_HIGH, 64'd0);
        send_item(1'b0);
        send_item(1'b0);
        drain();
        apb_write(REG_HIGH, 64'd1);
        check_regs();
        send_item(1'b0);
        send_item(1'b1);
        drain();

        // Inverted ranges: value 0, sum unchanged, count still moves.
        apb_write(REG_LOW, 64'd5);
        apb_write(REG_HIGH, 64'd4);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();
        apb_write(REG_LOW, 64'hFFFF_FFFF);
        apb_write(REG_HIGH, 64'd0);
        check_regs();
        send_item(1'b1);
        drain();

        // Span of two across the sign bit.
        apb_write(REG_SEED, 64'h8000_0000_0000_0000);
        apb_write(REG_LOW, 64'h7FFF_FFFF);
        apb_write(REG_HIGH, 64'h8000_0000);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        drain();

        // Write to an unmapped register must be ignored; full 32-bit range.
        apb_write(REG_UNUSED, 64'hDEAD_BEEF_0BAD_F00D);
        apb_write(REG_SEED, 64'd1);
        apb_write(REG_LOW, 64'd0);
        apb_write(REG_HIGH, 64'hFFFF_FFFF);
        check_regs();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        drain();

        apb_write(REG_LOW, 64'd1);
        send_item(1'b0);
        send_item(1'b1);
        drain();

        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 4))
                    0: begin
                        lo = 32'd0;
                        hi = 32'hFFFF_FFFF;
                    end
                    1: begin
                        lo = $urandom;
                        hi = lo;
                    end
                    2: begin
                        hi = $urandom_range(0, 255);
                        lo = hi + 32'd1 + $urandom_range(0, 100000);
                    end
                    3: begin
                        lo = $urandom;
                        hi = (lo > 32'hFFFF_FF00) ? 32'hFFFF_FFFF
                                                  : lo + $urandom_range(1, 200);
                    end
                    default: begin
                        lo = $urandom;
                        hi = $urandom;
                    end
                endcase
                apb_write(REG_LOW, {$urandom, lo});
                apb_write(REG_HIGH, {$urandom, hi});
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0: apb_write(REG_SEED, 64'd0);
                    1: apb_write(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
                    default: apb_write(REG_SEED, {$urandom, $urandom});
                endcase
            end
            check_regs();

            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            // Stall the result side for a long stretch while requests keep coming.
            if (phase == 3) begin
                gap_max       = 0;
                hold_receiver = 1;
            end
            n = $urandom_range(10, 60);
            if (phase == 5) begin
                // Pause the request side mid-phase until everything is back.
                send_run(n / 2);
                drain();
                send_run(n - n / 2);
            end else begin
                send_run(n);
            end
            drain();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.draws_due.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.draws_due.size()));
        $display("checked %0d draws over %0d random phases, %0d register writes",
                 sb.n_checked, phase, reg_writes);
        $display("%0d draws had an inverted range, %0d runs were closed by last",
                 sb.n_bad, sb.n_runs);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
